>>> hdl/assert_macros.svh
// Assertion helper macros for the scheduler RTL.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define CHK_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication checked at the same edge.
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/srpt_pkg.sv
// Shared types and constants for the SRPT completion-time scheduler.
// No dependencies.
package srpt_pkg;

  localparam logic [29:0] SUM_MOD = 30'd1000000007;
  // floor(2^48 / SUM_MOD), used to estimate the quotient of a 48-bit time
  localparam logic [18:0] SUM_RECIP = 19'd281474;
  localparam int MTW = 48;

  // Commands for the memory heap unit
  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_SWAP,
    OP_SIFT_DOWN,
    OP_PUSH
  } hp_op_t;

  typedef struct packed {
    logic   start;
    hp_op_t op;
  } hp_ctl_t;

  typedef enum logic [3:0] {
    HP_IDLE,
    HP_RD,
    HP_SW_A,
    HP_SW_B,
    HP_SW_C,
    HP_SD_V,
    HP_SD_NX,
    HP_SD_L,
    HP_SD_R,
    HP_SD_CMP,
    HP_SU_NX,
    HP_SU_P
  } hp_state_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_BUILD,
    S_SWAP,
    S_SORTD,
    S_SIM0,
    S_SIM0W,
    S_NEXT,
    S_NEXTW,
    S_LOOP,
    S_TOP,
    S_POPA,
    S_MOD,
    S_ADD,
    S_POPB,
    S_PUSH1,
    S_PUSH2,
    S_FIN
  } top_state_t;

endpackage

>>> hdl/srpt_total_completion_time.sv
// Top level of the SRPT total-completion-time scheduler.
// Depends on srpt_pkg, srpt_heap and assert_macros.svh.
//
// Input channel (in_valid/in_ready): one job word per cycle while loading,
// job_length and release_time, last_job closing the batch. Up to MAX_JOBS
// jobs are stored; later ones are dropped and flagged in dropped_jobs.
// After the closing word the input is held off while the batch is heap
// sorted by (release, length) in the job memory and a single machine is
// simulated with a min-heap of remaining times in a second memory.
// Each heap step uses the memory's one write and one registered read; a sift
// level passes through HP_SD_NX, HP_SD_L, HP_SD_R (with a right child) and
// HP_SD_CMP. Each completion time is reduced modulo 1000000007 by a
// reciprocal multiply in the S_MOD steps and then accumulated in S_ADD, the
// reduction running beside the heap sift.
// Output channel (out_valid/out_ready): one word per batch, completion_sum
// and dropped_jobs, held in an output register; loading of the next batch
// goes on while it waits. If a second result is ready before the first is
// taken, the block waits for the receiver.
// Reset (synchronous) empties the batch and clears out_valid.
module srpt_total_completion_time import srpt_pkg::*; #(
  parameter int MAX_JOBS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] job_length,
  input  logic [31:0] release_time,
  input  logic        last_job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [29:0] completion_sum,
  output logic        dropped_jobs
);

  `include "assert_macros.svh"

  localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);

  top_state_t    state, state_next;
  logic [CW-1:0] cnt, cnt_new, j, i, hs;
  logic          ovf;
  logic [MTW-1:0] mt, mt_lg;
  logic [29:0]   sum, r_mod;
  logic [30:0]   s_add;
  logic [2:0]    mod_step;
  logic [50:0]   q_prod;
  logic [18:0]   q_est;
  logic [48:0]   qm, qm_prod;
  logic [31:0]   r_wide, r_diff, r_red;
  logic [31:0]   jrel, jlen, lg_new;
  logic [31:0]   lg_hold;
  logic          fits, in_acc, has_room, more;

  hp_ctl_t       s_ctl, h_ctl;
  logic [AW-1:0] s_addr, h_addr;
  logic [CW-1:0] s_size, h_size;
  logic [63:0]   s_data, s_rvalue;
  logic [31:0]   h_data, h_rvalue;
  logic          s_busy, h_busy;

  // Job store: max-heap on {release, length}, used for the sort
  srpt_heap #(.DEPTH(MAX_JOBS), .W(64), .MIN_FIRST(1'b0)) u_store (
    .clk(clk), .rst(rst), .ctl(s_ctl), .addr(s_addr), .size(s_size),
    .data(s_data), .busy(s_busy), .rvalue(s_rvalue)
  );

  // Remaining-time min-heap
  srpt_heap #(.DEPTH(MAX_JOBS), .W(32), .MIN_FIRST(1'b1)) u_rem (
    .clk(clk), .rst(rst), .ctl(h_ctl), .addr(h_addr), .size(h_size),
    .data(h_data), .busy(h_busy), .rvalue(h_rvalue)
  );

  assign in_ready = (state == S_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign has_room = cnt < CW'(MAX_JOBS);
  assign cnt_new  = has_room ? cnt + CW'(1) : cnt;
  assign more     = i < cnt;
  assign mt_lg    = mt + MTW'(h_rvalue);
  assign fits     = !more || (mt_lg <= MTW'(jrel));
  assign lg_new   = 32'(mt_lg - MTW'(jrel));
  assign s_add    = {1'b0, sum} + {1'b0, r_mod};

  // Modulo reduction: quotient estimate is low by at most two
  assign q_prod  = 51'(mt[47:16]) * 51'(SUM_RECIP);
  assign qm_prod = 49'(q_est) * 49'(SUM_MOD);
  assign r_diff  = mt[31:0] - qm[31:0];
  assign r_red   = (r_wide >= {2'b0, SUM_MOD}) ? r_wide - {2'b0, SUM_MOD} : r_wide;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:  if (in_acc && last_job) state_next = S_BUILD;
      S_BUILD: if (!s_busy && j == '0) state_next = S_SWAP;
      S_SWAP:  if (!s_busy) state_next = (i == '0) ? S_SIM0 : S_SORTD;
      S_SORTD: if (!s_busy) state_next = S_SWAP;
      S_SIM0: begin
        if (cnt == '0) state_next = S_FIN;
        else if (!s_busy) state_next = S_SIM0W;
      end
      S_SIM0W: if (!s_busy && !h_busy) state_next = S_NEXT;
      S_NEXT: begin
        if (!more) state_next = S_LOOP;
        else if (!s_busy) state_next = S_NEXTW;
      end
      S_NEXTW: if (!s_busy) state_next = S_LOOP;
      S_LOOP: begin
        if (!h_busy) begin
          if (hs != '0) state_next = S_TOP;
          else if (more) state_next = S_NEXT;
          else state_next = S_FIN;
        end
      end
      S_TOP:   if (!h_busy) state_next = fits ? S_POPA : S_POPB;
      S_POPA:  if (!h_busy) state_next = S_MOD;
      S_MOD:   if (mod_step == '0) state_next = S_ADD;
      S_ADD:   state_next = S_LOOP;
      S_POPB:  if (!h_busy) state_next = S_PUSH1;
      S_PUSH1: if (!h_busy) state_next = S_PUSH2;
      S_PUSH2: if (!h_busy) state_next = S_NEXT;
      S_FIN:   if (!out_valid || out_ready) state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  // Heap unit commands
  always_comb begin
    s_ctl  = '{start: 1'b0, op: OP_READ};
    s_addr = i[AW-1:0];
    s_size = cnt;
    s_data = {release_time, job_length};
    h_ctl  = '{start: 1'b0, op: OP_READ};
    h_addr = hs[AW-1:0];
    h_size = hs;
    h_data = jlen;
    case (state)
      S_LOAD: begin
        s_ctl  = '{start: in_acc && has_room, op: OP_WRITE};
        s_addr = cnt[AW-1:0];
      end
      S_BUILD: begin
        s_ctl  = '{start: !s_busy && j != '0, op: OP_SIFT_DOWN};
        s_addr = AW'(j - CW'(1));
      end
      S_SWAP: s_ctl = '{start: !s_busy && i != '0, op: OP_SWAP};
      S_SORTD: begin
        s_ctl  = '{start: !s_busy, op: OP_SIFT_DOWN};
        s_addr = '0;
        s_size = i;
      end
      S_SIM0: begin
        s_ctl  = '{start: !s_busy && cnt != '0, op: OP_READ};
        s_addr = '0;
      end
      S_SIM0W: begin
        h_ctl  = '{start: !s_busy && !h_busy, op: OP_PUSH};
        h_addr = '0;
        h_data = s_rvalue[31:0];
      end
      S_NEXT: s_ctl = '{start: more && !s_busy, op: OP_READ};
      S_LOOP: begin
        if (hs == '0) begin
          h_ctl = '{start: !h_busy && more, op: OP_PUSH};
        end else begin
          h_ctl  = '{start: !h_busy, op: OP_READ};
          h_addr = '0;
        end
      end
      S_TOP: begin
        h_ctl  = '{start: !h_busy, op: OP_SWAP};
        h_addr = AW'(hs - CW'(1));
      end
      S_POPA, S_POPB: begin
        h_ctl  = '{start: !h_busy, op: OP_SIFT_DOWN};
        h_addr = '0;
      end
      S_PUSH1: begin
        h_ctl  = '{start: !h_busy, op: OP_PUSH};
        h_data = lg_hold;
      end
      S_PUSH2: h_ctl = '{start: !h_busy, op: OP_PUSH};
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      ovf       <= 1'b0;
      hs        <= '0;
      mt        <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            cnt <= cnt_new;
            if (!has_room) ovf <= 1'b1;
            j <= cnt_new >> 1;
            i <= (cnt_new == '0) ? '0 : cnt_new - CW'(1);
          end
        end
        S_BUILD: if (!s_busy && j != '0) j <= j - CW'(1);
        S_SORTD: if (!s_busy) i <= i - CW'(1);
        S_SIM0W: begin
          if (!s_busy && !h_busy) begin
            mt <= MTW'(s_rvalue[63:32]);
            hs <= CW'(1);
            i  <= CW'(1);
          end
        end
        S_NEXTW: begin
          if (!s_busy) begin
            jrel <= s_rvalue[63:32];
            jlen <= s_rvalue[31:0];
          end
        end
        S_LOOP: begin
          if (!h_busy && hs == '0 && more) begin
            mt <= MTW'(jrel);
            hs <= hs + CW'(1);
            i  <= i + CW'(1);
          end
        end
        S_TOP: begin
          if (!h_busy) begin
            hs <= hs - CW'(1);
            if (fits) begin
              mt       <= mt_lg;
              r_mod    <= '0;
              mod_step <= 3'd4;
            end else begin
              mt     <= MTW'(jrel);
              jlen   <= jlen;
            end
          end
        end
        S_MOD: begin
          case (mod_step)
            3'd4:    q_est  <= q_prod[50:32];
            3'd3:    qm     <= qm_prod;
            3'd2:    r_wide <= r_diff;
            3'd1:    r_wide <= r_red;
            default: r_mod  <= r_red[29:0];
          endcase
          mod_step <= mod_step - 3'd1;
        end
        S_ADD: sum <= (s_add >= {1'b0, SUM_MOD}) ? 30'(s_add - {1'b0, SUM_MOD}) : s_add[29:0];
        S_POPB: begin
          if (!h_busy) begin
            r_mod <= '0;
          end
        end
        S_PUSH1: if (!h_busy) hs <= hs + CW'(1);
        S_PUSH2: begin
          if (!h_busy) begin
            hs <= hs + CW'(1);
            i  <= i + CW'(1);
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            completion_sum <= sum;
            dropped_jobs   <= ovf;
            cnt            <= '0;
            ovf            <= 1'b0;
            hs             <= '0;
            mt             <= '0;
            sum            <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Remaining-time leftover kept until pushed
  always_ff @(posedge clk) begin
    if (state == S_TOP && !h_busy) lg_hold <= lg_new;
  end

  `CHK_ALWAYS(a_heap_le_cnt, hs <= cnt, "heap larger than batch")
  `CHK_ALWAYS(a_cnt_le_max, cnt <= CW'(MAX_JOBS), "job count beyond capacity")
  `CHK_IMPL(a_sum_range, state == S_FIN, sum < SUM_MOD, "sum not reduced")
  `CHK_IMPL(a_load_idle, in_ready, hs == '0 && !s_busy && !h_busy, "busy while loading")

endmodule

>>> hdl/srpt_heap.sv
// Binary heap held in a memory with one write port and one registered read port.
// Depends on srpt_pkg. Ops: write, read, swap with root, sift down, push.
module srpt_heap import srpt_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int W = 32,
  parameter bit MIN_FIRST = 1'b1,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  hp_ctl_t       ctl,
  input  logic [AW-1:0] addr,
  input  logic [CW-1:0] size,
  input  logic [W-1:0]  data,
  output logic          busy,
  output logic [W-1:0]  rvalue
);

  localparam int IW = AW + 2;

  logic [W-1:0]  mem [DEPTH];
  logic [W-1:0]  rdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [W-1:0]  wdata;

  hp_state_t     state, state_next;
  logic [AW-1:0] k, c;
  logic [CW-1:0] n;
  logic [W-1:0]  v, best;

  logic [IW-1:0] l_idx, r_idx;
  logic          has_l, has_r;
  logic [AW-1:0] k_m1, parent;

  function automatic logic better(input logic [W-1:0] a, input logic [W-1:0] b);
    return MIN_FIRST ? (a < b) : (a > b);
  endfunction

  assign l_idx  = {1'b0, k, 1'b1};
  assign r_idx  = l_idx + IW'(1);
  assign has_l  = l_idx < IW'(n);
  assign has_r  = r_idx < IW'(n);
  assign k_m1   = k - AW'(1);
  assign parent = k_m1 >> 1;
  assign busy   = (state != HP_IDLE);

  // Memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      HP_IDLE: begin
        if (ctl.start) begin
          case (ctl.op)
            OP_READ:      state_next = HP_RD;
            OP_SWAP:      state_next = HP_SW_A;
            OP_SIFT_DOWN: state_next = HP_SD_V;
            OP_PUSH:      state_next = HP_SU_NX;
            default:      state_next = HP_IDLE;
          endcase
        end
      end
      HP_RD:     state_next = HP_IDLE;
      HP_SW_A:   state_next = HP_SW_B;
      HP_SW_B:   state_next = HP_SW_C;
      HP_SW_C:   state_next = HP_IDLE;
      HP_SD_V:   state_next = HP_SD_NX;
      HP_SD_NX:  state_next = has_l ? HP_SD_L : HP_IDLE;
      HP_SD_L:   state_next = has_r ? HP_SD_R : HP_SD_CMP;
      HP_SD_R:   state_next = HP_SD_CMP;
      HP_SD_CMP: state_next = better(best, v) ? HP_SD_NX : HP_IDLE;
      HP_SU_NX:  state_next = (k == '0) ? HP_IDLE : HP_SU_P;
      HP_SU_P:   state_next = better(v, rdata) ? HP_SU_NX : HP_IDLE;
      default:   state_next = HP_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    we    = 1'b0;
    waddr = k;
    wdata = v;
    raddr = k;
    case (state)
      HP_IDLE: begin
        raddr = (ctl.op == OP_SWAP) ? '0 : addr;
        waddr = addr;
        wdata = data;
        we    = ctl.start && (ctl.op == OP_WRITE);
      end
      HP_SW_B: begin
        we    = 1'b1;
        waddr = '0;
        wdata = rdata;
      end
      HP_SW_C: we = 1'b1;
      HP_SD_NX: begin
        raddr = l_idx[AW-1:0];
        we    = !has_l;
      end
      HP_SD_L: raddr = r_idx[AW-1:0];
      HP_SD_CMP: begin
        we    = 1'b1;
        wdata = better(best, v) ? best : v;
      end
      HP_SU_NX: begin
        raddr = parent;
        we    = (k == '0);
      end
      HP_SU_P: begin
        we    = 1'b1;
        wdata = better(v, rdata) ? rdata : v;
      end
      default: ;
    endcase
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HP_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      HP_IDLE: begin
        if (ctl.start) begin
          k <= addr;
          n <= size;
          v <= data;
        end
      end
      HP_RD:   rvalue <= rdata;
      HP_SW_A: v <= rdata;
      HP_SD_V: v <= rdata;
      HP_SD_L: begin
        best <= rdata;
        c    <= l_idx[AW-1:0];
      end
      HP_SD_R: begin
        if (better(rdata, best)) begin
          best <= rdata;
          c    <= r_idx[AW-1:0];
        end
      end
      HP_SD_CMP: if (better(best, v)) k <= c;
      HP_SU_P:   if (better(v, rdata)) k <= parent;
      default: ;
    endcase
  end

endmodule
